[rtl/core/mosaic_pkg.sv]
// Shared constants for the mosaic pixelation block: register indexes, modes, field widths.
`timescale 1ns / 1ps

package mosaic_pkg;

    localparam int PIX_W   = 8;
    localparam int CNT_W   = 12;
    localparam int PHASE_W = 6;
    localparam int DIM_W   = 13;
    localparam int BS_W    = 7;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 2'd3;

    localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [BS_W-1:0]   RST_BLOCK_SIZE   = 7'd10;
    localparam logic [MODE_W-1:0] RST_CHANNEL_MODE = MODE_RGB;

    localparam logic [DIM_W-1:0]  MAX_HEIGHT = 13'd4096;
    localparam logic [BS_W-1:0]   MAX_BLOCK  = 7'd64;

    typedef logic [3*PIX_W-1:0] pixel_t;

endpackage

[rtl/core/block_mosaic_pixelate.sv]
// Top level of the mosaic pixelation filter for a raster-order pixel stream.
//
// Usage:
//   s_* channel: one pixel per item (chan0..chan3, frame_start), valid/ready.
//   m_* channel: one result item per input item, in order (out0..out3,
//   frame_last), valid/ready.
//   cfg_* channel: register writes (frame_width, frame_height, block_size,
//   channel_mode); always ready. Write only while the stream is idle.
// Every output pixel repeats the top-left pixel of its square block; in
// one-channel mode the second and third channel read zero. Anchors live in
// a one-port-write, one-port-read memory of one entry per block column,
// captured on the first row of a block row and read back by the other pixels.
// Timing: the memory read register and the read stage load at the input
// accept edge, then the output register, which raises m_valid. Throughput:
// one item per cycle while m_ready stays high; each item reads the memory
// once, and a capturing pixel also writes it in the same cycle.
// Reset: counters clear, registers take their defaults (640 x 480, block 10,
// three channels); the anchor memory is not cleared.
// Stall: when m_ready is low the output holds, one more item may enter the
// read stage, then s_ready drops until the output drains.
`timescale 1ns / 1ps

module block_mosaic_pixelate
    import mosaic_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    // input pixel items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_chan0,
    input  logic [PIX_W-1:0]     s_chan1,
    input  logic [PIX_W-1:0]     s_chan2,
    input  logic [PIX_W-1:0]     s_chan3,
    input  logic                 s_frame_start,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_out0,
    output logic [PIX_W-1:0]     m_out1,
    output logic [PIX_W-1:0]     m_out2,
    output logic                 m_out3,
    output logic                 m_frame_last
);

    // The effective width never exceeds 4096, so the store needs no more entries.
    localparam int DEPTH = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [DIM_W-1:0] WMAX = DIM_W'(DEPTH);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [BS_W-1:0]   block_size_reg;
    logic [MODE_W-1:0] channel_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            block_size_reg   <= RST_BLOCK_SIZE;
            channel_mode_reg <= RST_CHANNEL_MODE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_BLOCK_SIZE:   block_size_reg   <= cfg_data[BS_W-1:0];
                CFG_CHANNEL_MODE: channel_mode_reg <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the limits: zero acts as one, oversize values saturate.
    logic [DIM_W-1:0] width_lim;
    logic [DIM_W-1:0] height_lim;
    logic [BS_W-1:0]  bs_lim;

    always_comb begin
        if (frame_width_reg == '0)        width_lim = DIM_W'(1);
        else if (frame_width_reg > WMAX)  width_lim = WMAX;
        else                              width_lim = frame_width_reg;

        if (frame_height_reg == '0)             height_lim = DIM_W'(1);
        else if (frame_height_reg > MAX_HEIGHT) height_lim = MAX_HEIGHT;
        else                                    height_lim = frame_height_reg;

        if (block_size_reg == '0)            bs_lim = BS_W'(1);
        else if (block_size_reg > MAX_BLOCK) bs_lim = MAX_BLOCK;
        else                                 bs_lim = block_size_reg;
    end

    // ---------------------------------------------------------------
    // Handshake: read stage (s1) feeding the output register
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic adv_out;
    logic in_acc;

    // Advance the output when it is empty or being taken.
    assign adv_out = !out_valid_reg || m_ready;
    // Take a new item when the read stage is empty or moving on.
    assign s_ready = !s1_valid_reg || adv_out;
    assign in_acc  = s_valid && s_ready;

    // ---------------------------------------------------------------
    // Raster position
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [PHASE_W-1:0] col_ph_reg,  col_ph_next;
    logic [PHASE_W-1:0] row_ph_reg,  row_ph_next;
    logic [CNT_W-1:0]   blk_col_reg, blk_col_next;

    logic [CNT_W-1:0]   col_cur, row_cur, blk_cur;
    logic [PHASE_W-1:0] col_ph_cur, row_ph_cur;
    logic               capture;
    logic               last_pix;

    always_comb begin
        // frame_start clears the position before this pixel is placed
        col_cur    = s_frame_start ? '0 : col_cnt_reg;
        row_cur    = s_frame_start ? '0 : row_cnt_reg;
        col_ph_cur = s_frame_start ? '0 : col_ph_reg;
        row_ph_cur = s_frame_start ? '0 : row_ph_reg;
        blk_cur    = s_frame_start ? '0 : blk_col_reg;

        capture  = (row_ph_cur == '0) && (col_ph_cur == '0);
        last_pix = ({1'b0, col_cur} == width_lim - DIM_W'(1))
                && ({1'b0, row_cur} == height_lim - DIM_W'(1));

        row_cnt_next = row_cur;
        row_ph_next  = row_ph_cur;
        if ({1'b0, col_cur} + DIM_W'(1) >= width_lim) begin
            // end of line: wrap column, step row
            col_cnt_next = '0;
            col_ph_next  = '0;
            blk_col_next = '0;
            if ({1'b0, row_cur} + DIM_W'(1) >= height_lim) begin
                row_cnt_next = '0;
                row_ph_next  = '0;
            end else begin
                row_cnt_next = row_cur + CNT_W'(1);
                if ({1'b0, row_ph_cur} + BS_W'(1) >= bs_lim) begin
                    row_ph_next = '0;
                end else begin
                    row_ph_next = row_ph_cur + PHASE_W'(1);
                end
            end
        end else begin
            col_cnt_next = col_cur + CNT_W'(1);
            if ({1'b0, col_ph_cur} + BS_W'(1) >= bs_lim) begin
                col_ph_next  = '0;
                blk_col_next = blk_cur + CNT_W'(1);
            end else begin
                col_ph_next  = col_ph_cur + PHASE_W'(1);
                blk_col_next = blk_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            col_ph_reg  <= '0;
            row_ph_reg  <= '0;
            blk_col_reg <= '0;
        end else if (in_acc) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            col_ph_reg  <= col_ph_next;
            row_ph_reg  <= row_ph_next;
            blk_col_reg <= blk_col_next;
        end
    end

    // ---------------------------------------------------------------
    // Anchor memory: write and read at the accept edge. The read returns
    // the value from before this edge, so every earlier capture is seen.
    // ---------------------------------------------------------------
    pixel_t         anchor_mem [DEPTH];
    pixel_t         rd_data_reg;
    pixel_t         s1_pix_reg;
    logic           s1_cap_reg;
    logic           s1_last_reg;
    logic [AW-1:0]  mem_addr;
    pixel_t         pix_in;

    // block column stays below the effective width, hence below DEPTH
    assign mem_addr = blk_cur[AW-1:0];
    assign pix_in   = {s_chan2, s_chan1, s_chan0};

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (capture) begin
                anchor_mem[mem_addr] <= pix_in;
            end
            rd_data_reg <= anchor_mem[mem_addr];
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_pix_reg  <= pix_in;
            s1_cap_reg  <= capture;
            s1_last_reg <= last_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    pixel_t anchor_sel;
    logic [PIX_W-1:0] out0_reg, out1_reg, out2_reg;
    logic             last_reg;

    // a capturing pixel is its own anchor
    assign anchor_sel = s1_cap_reg ? s1_pix_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (adv_out && s1_valid_reg) begin
            out0_reg <= anchor_sel[PIX_W-1:0];
            // drop the second and third channel in one-channel mode
            if (channel_mode_reg == MODE_MONO) begin
                out1_reg <= '0;
                out2_reg <= '0;
            end else begin
                out1_reg <= anchor_sel[2*PIX_W-1:PIX_W];
                out2_reg <= anchor_sel[3*PIX_W-1:2*PIX_W];
            end
            last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv_out) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out0       = out0_reg;
    assign m_out1       = out1_reg;
    assign m_out2       = out2_reg;
    assign m_out3       = 1'b0;    // alpha is always zero; s_chan3 is not carried
    assign m_frame_last = last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are full and stalled");

    a_frame_start_captures: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_frame_start) |=> (s1_valid_reg && s1_cap_reg))
        else $error("first pixel of a frame did not capture an anchor");

    a_block_col_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        blk_col_reg <= col_cnt_reg)
        else $error("block column ran ahead of column count");

    a_mono_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv_out && s1_valid_reg && channel_mode_reg == MODE_MONO) |=>
            (m_out1 == '0 && m_out2 == '0))
        else $error("upper channels not cleared in one-channel mode");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && adv_out && !in_acc) |=> (out_valid_reg && !s1_valid_reg))
        else $error("read stage item lost or duplicated");

endmodule

[tb/sv/block_mosaic_pixelate_test.sv]
// Self-checking testbench for the mosaic pixelation block with a built-in pixel predictor.
`timescale 1ns / 1ps

module block_mosaic_pixelate_test;
    import mosaic_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int WIDTH_CAP   = (MAX_W < 4096) ? MAX_W : 4096;
    localparam int RAND_ITEMS  = 1400;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    // Channel modes without a name in the package
    localparam logic [MODE_W-1:0] MODE_RGBA = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] chan0;
        logic [PIX_W-1:0] chan1;
        logic [PIX_W-1:0] chan2;
        logic [PIX_W-1:0] chan3;
        logic             frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out0;
        logic [PIX_W-1:0] out1;
        logic [PIX_W-1:0] out2;
        logic             out3;
        logic             frame_last;
    } mosaic_out_t;

    // Clock, reset and block ports; every input starts at a known value
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    pixel_in_t            s_pix     = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [PIX_W-1:0]     m_out0;
    logic [PIX_W-1:0]     m_out1;
    logic [PIX_W-1:0]     m_out2;
    logic                 m_out3;
    logic                 m_frame_last;

    // Pending pixels for the driver and mosaic outputs still owed by the block
    pixel_in_t   pixel_q[$];
    mosaic_out_t mosaic_q[$];

    int n_queued      = 0;
    int n_results     = 0;
    int errors        = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int idle_cycles   = 0;
    int src_wait      = 0;
    int sink_wait     = 0;
    bit src_burst     = 1'b0;
    bit sink_burst    = 1'b0;

    // Predictor copy of the registers and the raster position
    logic [DIM_W-1:0]  cfg_w;
    logic [DIM_W-1:0]  cfg_h;
    logic [BS_W-1:0]   cfg_bs;
    logic [MODE_W-1:0] cfg_mode;
    int     col_cnt;
    int     row_cnt;
    int     col_ph;
    int     row_ph;
    int     blk_col;
    pixel_t anchors [MAX_W];

    wire any_accept = (s_valid && s_ready) || (m_valid && m_ready) ||
                      (cfg_valid && cfg_ready);

    block_mosaic_pixelate #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_chan0      (s_pix.chan0),
        .s_chan1      (s_pix.chan1),
        .s_chan2      (s_pix.chan2),
        .s_chan3      (s_pix.chan3),
        .s_frame_start(s_pix.frame_start),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out0       (m_out0),
        .m_out1       (m_out1),
        .m_out2       (m_out2),
        .m_out3       (m_out3),
        .m_frame_last (m_frame_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Work out the mosaic output for one accepted pixel and advance the raster position.
    function automatic mosaic_out_t pixelate_pixel(pixel_in_t p);
        int          w;
        int          h;
        int          bs;
        pixel_t      pix;
        pixel_t      anchor;
        mosaic_out_t r;
        w  = (cfg_w == 0) ? 1 : ((int'(cfg_w) > WIDTH_CAP) ? WIDTH_CAP : int'(cfg_w));
        h  = (cfg_h == 0) ? 1 : ((cfg_h > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(cfg_h));
        bs = (cfg_bs == 0) ? 1 : ((cfg_bs > MAX_BLOCK) ? int'(MAX_BLOCK) : int'(cfg_bs));
        pix    = {p.chan2, p.chan1, p.chan0};
        anchor = '0;

        // frame start pulls the position back to the top-left corner first
        if (p.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
            col_ph  = 0;
            row_ph  = 0;
            blk_col = 0;
        end

        // capture on the block's top-left pixel, read back everywhere else
        if (row_ph == 0 && col_ph == 0) begin
            if (blk_col < MAX_W) anchors[blk_col] = pix;
            anchor = pix;
        end else if (blk_col < MAX_W) begin
            anchor = anchors[blk_col];
        end

        r.out0 = anchor[PIX_W-1:0];
        if (cfg_mode == MODE_MONO) begin
            r.out1 = '0;
            r.out2 = '0;
        end else begin
            r.out1 = anchor[2*PIX_W-1:PIX_W];
            r.out2 = anchor[3*PIX_W-1:2*PIX_W];
        end
        r.out3       = 1'b0;
        r.frame_last = (col_cnt == w - 1) && (row_cnt == h - 1);

        // advance; wrap at the frame end even without a frame start
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            col_ph  = 0;
            blk_col = 0;
            if (row_cnt + 1 >= h) begin
                row_cnt = 0;
                row_ph  = 0;
            end else begin
                row_cnt++;
                row_ph = (row_ph + 1 >= bs) ? 0 : row_ph + 1;
            end
        end else begin
            col_cnt++;
            if (col_ph + 1 >= bs) begin
                col_ph = 0;
                blk_col++;
            end else begin
                col_ph++;
            end
        end
        return r;
    endfunction

    // Track register writes and reset in the predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w    = RST_FRAME_WIDTH;
            cfg_h    = RST_FRAME_HEIGHT;
            cfg_bs   = RST_BLOCK_SIZE;
            cfg_mode = RST_CHANNEL_MODE;
            col_cnt  = 0;
            row_cnt  = 0;
            col_ph   = 0;
            row_ph   = 0;
            blk_col  = 0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    cfg_w = cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    cfg_h = cfg_data;
                end
                CFG_BLOCK_SIZE: begin
                    cfg_bs = cfg_data[BS_W-1:0];
                end
                CFG_CHANNEL_MODE: begin
                    cfg_mode = cfg_data[MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Driver: predict on every accepted item, then hold off for a drawn
    // number of cycles before offering the next one from the queue.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_valid && s_ready) mosaic_q.push_back(pixelate_pixel(s_pix));
            if (!s_valid || s_ready) begin
                if (src_wait != 0) begin
                    s_valid <= 1'b0;
                    src_wait--;
                end else if (pixel_q.size() != 0) begin
                    s_pix    <= pixel_q.pop_front();
                    s_valid  <= 1'b1;
                    src_wait = src_burst ? 0 : $urandom_range(0, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(string msg);
        $display("%s", msg);
        errors++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report($sformatf("mismatch: result %0d %s got 0x%0h want 0x%0h",
                             n_results, name, got, want));
    endtask

    // Monitor: compare every accepted result against the oldest prediction,
    // then draw the stall before the next one. A hold request stalls long.
    always @(posedge aclk) begin : monitor
        mosaic_out_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mosaic_q.size() == 0) begin
                    report($sformatf("unexpected result %0d: no prediction waiting", n_results));
                end else begin
                    want = mosaic_q.pop_front();
                    check_field("out0", int'(m_out0), int'(want.out0));
                    check_field("out1", int'(m_out1), int'(want.out1));
                    check_field("out2", int'(m_out2), int'(want.out2));
                    check_field("out3", int'(m_out3), int'(want.out3));
                    check_field("frame_last", int'(m_frame_last), int'(want.frame_last));
                end
                n_results++;
                sink_wait = sink_burst ? 0 : $urandom_range(0, 9);
            end
            if (hold_requests != holds_done) begin
                sink_wait = HOLD_CYCLES;
                holds_done++;
            end
            if (sink_wait != 0) begin
                m_ready <= 1'b0;
                sink_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || any_accept) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Start a write at the current edge and return at its handshake edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                logic [BS_W-1:0] bs, logic [MODE_W-1:0] mode);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_BLOCK_SIZE, DIM_W'(bs));
        write_reg(CFG_CHANNEL_MODE, DIM_W'(mode));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                              logic [PIX_W-1:0] c2, logic [PIX_W-1:0] c3, logic fs);
        pixel_q.push_back('{chan0: c0, chan1: c1, chan2: c2, chan3: c3, frame_start: fs});
        n_queued++;
    endtask

    // Random pixels; the first one starts a frame so every anchor read was captured.
    task automatic push_frame_run(int n);
        for (int i = 0; i < n; i++)
            push_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       (i == 0) || ($urandom_range(0, 49) == 0));
    endtask

    // Wait until every prediction is matched, then let the pipeline settle.
    task automatic drain();
        while (n_results != n_queued || pixel_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int rand_items;
        int w;
        int h;
        int bs;
        int n;
        logic [MODE_W-1:0] mode;
        rand_items = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: 640 wide, block 10; the eleventh pixel opens block column 1
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
        push_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
        for (int i = 0; i < 6; i++) push_pixel(8'h01 << i, 8'h80 >> i, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        drain();

        // 3x2 frame, block 2, one channel: runs past the frame end without a
        // frame start, then restarts mid-frame
        write_config(13'd3, 13'd2, 7'd2, MODE_MONO);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h7F, 8'h80, 8'hFE, 8'h01, 1'b0);
        push_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        push_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'hC3, 8'h3C, 8'hC3, 8'h3C, 1'b0);
        push_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
        push_pixel(8'hEE, 8'hDD, 8'hCC, 8'hBB, 1'b1);
        drain();

        // Zero sizes read as one: every pixel is a whole frame; mode 3 acts as mode 2
        write_config(13'd0, 13'd0, 7'd0, MODE_RSVD);
        push_pixel(8'hA5, 8'h5A, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'h5A, 8'hA5, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'h00, 8'h81, 8'h7E, 1'b0);
        drain();

        // Size extremes: saturation above the limits, exact limits, just above, minimum
        write_config(13'h1FFF, 13'h1FFF, 7'h7F, MODE_RSVD);
        push_frame_run(100);
        drain();
        write_config(13'd4096, 13'd4096, MAX_BLOCK, MODE_RGBA);
        push_frame_run(100);
        drain();
        write_config(13'd4097, 13'd4097, 7'd65, MODE_MONO);
        push_frame_run(60);
        drain();
        write_config(13'd1, 13'd1, 7'd1, MODE_RGB);
        push_frame_run(40);
        drain();
        rand_items += 300;

        // Back-pressure: the sender streams flat out while the receiver holds
        // off long enough for the block to fill and drop s_ready
        write_config(13'd16, 13'd8, 7'd4, MODE_RGB);
        src_burst  = 1'b1;
        sink_burst = 1'b0;
        push_frame_run(200);
        hold_requests++;
        drain();
        rand_items += 200;

        // Random small frames, mostly complete, with random idling per phase
        while (rand_items < RAND_ITEMS) begin
            w  = $urandom_range(1, 24);
            h  = $urandom_range(1, 10);
            bs = $urandom_range(1, 9);
            case ($urandom_range(0, 9))
                0: bs = int'(MAX_BLOCK);
                1: bs = 0;
                2: w = $urandom_range(25, 200);
                default: begin
                end
            endcase
            mode       = MODE_W'($urandom_range(0, 3));
            n          = $urandom_range(40, 120);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            write_config(DIM_W'(w), DIM_W'(h), BS_W'(bs), mode);
            push_frame_run(n);
            drain();
            rand_items += n;
        end

        repeat (10) @(posedge aclk);
        if (mosaic_q.size() != 0)
            report($sformatf("%0d predicted results never arrived", mosaic_q.size()));
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mosaic_pkg.sv
rtl/core/block_mosaic_pixelate.sv
tb/sv/block_mosaic_pixelate_test.sv
